// ----- rtl/binary_mask_shrink_expand_defines.svh -----
// Assertion macros for the mask shrink/expand block.
// Each macro checks a property on the rising edge of clk_i, off while rst_ni is low.
`ifndef BINARY_MASK_SHRINK_EXPAND_DEFINES_SVH
`define BINARY_MASK_SHRINK_EXPAND_DEFINES_SVH

`ifndef SYNTHESIS

`define BMSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bmse assertion failed");

`define BMSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bmse assertion failed");

`else

`define BMSE_ASSERT_IMP(lbl, ante, cons)

`define BMSE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/bmse_pkg.sv -----
package bmse_pkg;

  typedef struct packed {
    logic pixel_in;
    logic is_padding;
  } in_beat_t;

  typedef struct packed {
    logic        pixel_out;
    logic [10:0] out_x;
    logic [10:0] out_y;
    logic        last_of_frame;
  } out_beat_t;

  typedef enum logic [1:0] {
    REG_MODE          = 2'd0,
    REG_IMAGE_WIDTH   = 2'd1,
    REG_IMAGE_HEIGHT  = 2'd2,
    REG_MIN_NEIGHBORS = 2'd3
  } reg_idx_e;

  localparam logic        MODE_EXPAND        = 1'b1;
  localparam logic        MODE_RST           = 1'b0;
  localparam logic [11:0] IMAGE_WIDTH_RST    = 12'd2048;
  localparam logic [11:0] IMAGE_HEIGHT_RST   = 12'd2048;
  localparam logic [3:0]  MIN_NEIGHBORS_RST  = 4'd7;

  // window bit index is row*3+col, col 2 being the newest column
  localparam logic [8:0]  WIN_KEEP_MASK      = 9'h0DB;
  localparam logic [8:0]  WIN_NEIGHBOR_MASK  = 9'h1EF;
  localparam int unsigned WIN_CENTER         = 4;
  localparam int unsigned WIN_TOP_BIT        = 2;
  localparam int unsigned WIN_MID_BIT        = 5;
  localparam int unsigned WIN_BOT_BIT        = 8;

endpackage

// ----- rtl/binary_mask_shrink_expand.sv -----
// Streaming 3x3 binary shrink (erode with neighbor count) / expand (dilate) on a raster
// mask. One input beat is taken per clock; each result trails its input by
// image_width + 1 beats, and image_width + 1 padding beats after the frame drain the
// last row. Outside the clearing pass input stalls only while both output slots (result
// register plus skid slot) are full, so throughput is one pixel per clock whenever the
// consumer keeps up. The two line buffers share one MAX_WIDTH x 2 bit memory with one
// write and one registered read per cycle. After reset a clearing pass zeroes that
// memory; input is stalled during it, configuration writes are taken as usual.
`include "binary_mask_shrink_expand_defines.svh"

module binary_mask_shrink_expand #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bmse_pkg::in_beat_t  in_data_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bmse_pkg::out_beat_t out_data_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned WCW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 3);

  // configuration registers
  logic        mode_q;
  logic [11:0] width_q;
  logic [11:0] height_q;
  logic [3:0]  min_nb_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= bmse_pkg::MODE_RST;
      width_q  <= bmse_pkg::IMAGE_WIDTH_RST;
      height_q <= bmse_pkg::IMAGE_HEIGHT_RST;
      min_nb_q <= bmse_pkg::MIN_NEIGHBORS_RST;
    end else if (cfg_we) begin
      unique case (bmse_pkg::reg_idx_e'(paddr[3:2]))
        bmse_pkg::REG_MODE:          mode_q   <= pwdata[0];
        bmse_pkg::REG_IMAGE_WIDTH:   width_q  <= pwdata[11:0];
        bmse_pkg::REG_IMAGE_HEIGHT:  height_q <= pwdata[11:0];
        bmse_pkg::REG_MIN_NEIGHBORS: min_nb_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (bmse_pkg::reg_idx_e'(paddr[3:2]))
      bmse_pkg::REG_MODE:          prdata = {31'd0, mode_q};
      bmse_pkg::REG_IMAGE_WIDTH:   prdata = {20'd0, width_q};
      bmse_pkg::REG_IMAGE_HEIGHT:  prdata = {20'd0, height_q};
      bmse_pkg::REG_MIN_NEIGHBORS: prdata = {28'd0, min_nb_q};
      default:                     prdata = 32'd0;
    endcase
  end

  // effective geometry: zero acts as one, oversize clamps to the maximum
  logic [31:0]    w_sel, h_sel;
  logic [WCW-1:0] w_eff;
  logic [RW-1:0]  h_eff;

  always_comb begin
    if (width_q == 12'd0) begin
      w_sel = 32'd1;
    end else if ({20'd0, width_q} > MAX_WIDTH) begin
      w_sel = MAX_WIDTH;
    end else begin
      w_sel = {20'd0, width_q};
    end
    if (height_q == 12'd0) begin
      h_sel = 32'd1;
    end else if ({20'd0, height_q} > MAX_HEIGHT) begin
      h_sel = MAX_HEIGHT;
    end else begin
      h_sel = {20'd0, height_q};
    end
  end

  assign w_eff = w_sel[WCW-1:0];
  assign h_eff = h_sel[RW-1:0];

  // clearing pass and line memory
  logic          clearing_q;
  logic [CW-1:0] clr_addr_q;
  logic [1:0]    line_mem [MAX_WIDTH];  // {upper, middle}
  logic [1:0]    line_rd_q;
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;
  logic [CW-1:0] mem_raddr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + CW'(1);
      if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    // forward a same-cycle write to the read port
    if (mem_we && (mem_waddr == mem_raddr)) begin
      line_rd_q <= mem_wdata;
    end else begin
      line_rd_q <= line_mem[mem_raddr];
    end
  end

  // position and window state
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [8:0]    win_q, win_d;

  // output register plus skid slot
  logic                out_valid_q, skid_valid_q;
  bmse_pkg::out_beat_t out_q, skid_q;

  logic                accept, produce;
  bmse_pkg::out_beat_t beat;

  function automatic logic judge(input logic [8:0] win, input logic expand,
                                 input logic [3:0] min_nb);
    logic [8:0] others;
    logic [3:0] cnt;
    others = win & bmse_pkg::WIN_NEIGHBOR_MASK;
    cnt    = '0;
    for (int b = 0; b < 9; b++) begin
      cnt = cnt + {3'd0, others[b]};
    end
    if (expand == bmse_pkg::MODE_EXPAND) begin
      judge = |win;
    end else begin
      judge = win[bmse_pkg::WIN_CENTER] && (cnt >= min_nb);
    end
  endfunction

  assign in_stall_o = clearing_q || skid_valid_q;
  assign accept     = in_valid_i && !in_stall_o;

  logic          pix, top, mid;
  logic [8:0]    col_bits, win_shift;
  logic          r_ge1, r_ge2, r_lt_h1, r_lt_h2, r_eq_h1, frame_end;
  logic [RW-1:0] h_p1, h_p2;
  logic          emit;

  always_comb begin
    h_p1    = h_eff + RW'(1);
    h_p2    = h_eff + RW'(2);
    r_ge1   = (row_q != '0);
    r_ge2   = (row_q >= RW'(2));
    r_lt_h1 = (row_q < h_p1);
    r_lt_h2 = (row_q < h_p2);
    r_eq_h1 = (row_q == h_p1);

    pix = in_data_i.pixel_in && !in_data_i.is_padding && (row_q < h_eff);
    top = r_ge2 && line_rd_q[1];
    mid = r_ge1 && line_rd_q[0];

    col_bits = '0;
    col_bits[bmse_pkg::WIN_TOP_BIT] = top;
    col_bits[bmse_pkg::WIN_MID_BIT] = mid;
    col_bits[bmse_pkg::WIN_BOT_BIT] = pix;

    win_shift = (win_q >> 1) & bmse_pkg::WIN_KEEP_MASK;

    beat          = '0;
    emit          = 1'b0;
    frame_end     = 1'b0;
    win_d         = win_q;
    if (col_q == '0) begin
      // row start: finish the last pixel of the row two above
      if (r_ge2) begin
        if (r_lt_h2) begin
          emit               = 1'b1;
          beat.pixel_out     = judge(win_shift, mode_q, min_nb_q);
          beat.out_x         = 11'(32'(w_eff) - 32'd1);
          beat.out_y         = 11'(32'(row_q) - 32'd2);
          beat.last_of_frame = r_eq_h1;
        end
        frame_end = !r_lt_h1;
      end
      win_d = col_bits;
    end else begin
      win_d = win_shift | col_bits;
      if (r_ge1 && r_lt_h1) begin
        emit           = 1'b1;
        beat.pixel_out = judge(win_d, mode_q, min_nb_q);
        beat.out_x     = 11'(32'(col_q) - 32'd1);
        beat.out_y     = 11'(32'(row_q) - 32'd1);
      end
    end

    if (frame_end) begin
      col_d = '0;
      row_d = '0;
      win_d = '0;
    end else if ((WCW'(col_q) + WCW'(1)) >= w_eff) begin
      col_d = '0;
      row_d = row_q + RW'(1);
    end else begin
      col_d = col_q + CW'(1);
      row_d = row_q;
    end
    if (!accept) begin
      col_d = col_q;
      row_d = row_q;
      win_d = win_q;
    end
  end

  assign produce   = accept && emit;
  assign mem_we    = clearing_q || accept;
  assign mem_waddr = clearing_q ? clr_addr_q : col_q;
  assign mem_wdata = clearing_q ? 2'b00 : {mid, pix};
  // prefetch the line entry for the next beat's column
  assign mem_raddr = col_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      win_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      // drain skid first; a new beat cannot arrive while it is full
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= produce;
      end
    end else if (produce) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= skid_valid_q ? skid_q : beat;
    end else if (produce) begin
      skid_q <= beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BMSE_ASSERT_IMP(a_skid_implies_out, skid_valid_q, out_valid_q)
  `BMSE_ASSERT_IMP(a_no_output_while_clearing, clearing_q, !out_valid_q)
  `BMSE_ASSERT_NXT(a_stalled_result_to_skid, produce && out_valid_q && out_stall_i, skid_valid_q)
  `BMSE_ASSERT_NXT(a_last_restarts_frame, produce && beat.last_of_frame, (row_q == '0) && (col_q == '0))

endmodule
